// File: design/frp_pkg.sv
// frp_pkg: shared types and constants of the frame receive parser
// holds event codes, register indexes, reset values and the result/config structs
// no dependencies
package frp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned EvW   = 2;

  // configuration register indexes
  localparam logic CfgHead = 1'b0;
  localparam logic CfgTail = 1'b1;

  // register reset values
  localparam logic [ByteW-1:0] HeadReset = 8'hF5;
  localparam logic [ByteW-1:0] TailReset = 8'h5F;

  // frame event reported with each byte
  typedef enum logic [EvW-1:0] {
    EV_NONE     = 2'd0,
    EV_OK       = 2'd1,
    EV_SUM_BAD  = 2'd2,
    EV_TAIL_BAD = 2'd3
  } evt_e;

  typedef struct packed {
    logic [ByteW-1:0] head_code;
    logic [ByteW-1:0] tail_code;
  } cfg_t;

  typedef struct packed {
    evt_e             event_res;
    logic [ByteW-1:0] frame_command;
    logic [LenW-1:0]  frame_length;
    logic             payload_valid;
    logic [LenW-1:0]  payload_index;
    logic [ByteW-1:0] payload_byte;
  } res_t;

endpackage

// File: design/frp_cfg_regs.sv
// frp_cfg_regs: head and tail code registers behind the plain write port
// depends on frp_pkg
module frp_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_addr_i,
  input  logic [frp_pkg::ByteW-1:0] cfg_wdata_i,
  output frp_pkg::cfg_t            cfg_o
);

  frp_pkg::cfg_t cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_code <= frp_pkg::HeadReset;
      cfg_q.tail_code <= frp_pkg::TailReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        frp_pkg::CfgHead: cfg_q.head_code <= cfg_wdata_i;
        frp_pkg::CfgTail: cfg_q.tail_code <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/frp_parser.sv
// frp_parser: frame phase machine, length/command/checksum state and result logic
// depends on frp_pkg
module frp_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [frp_pkg::ByteW-1:0] byte_i,
  input  frp_pkg::cfg_t             cfg_i,
  output frp_pkg::res_t             res_o
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_CMD    = 3'd3,
    PH_DATA   = 3'd4,
    PH_SUM    = 3'd5,
    PH_TAIL   = 3'd6
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [frp_pkg::LenW-1:0]  length_q, length_d;
  logic [frp_pkg::LenW-1:0]  remaining_q, remaining_d;
  logic [frp_pkg::ByteW-1:0] command_q, command_d;
  logic [frp_pkg::ByteW-1:0] sum_q, sum_d;
  frp_pkg::evt_e             ev;
  logic                      pvalid;
  logic [frp_pkg::LenW-1:0]  pindex;
  logic [frp_pkg::ByteW-1:0] pbyte;

  // next state and result for the byte in hand
  always_comb begin
    phase_d     = phase_q;
    length_d    = length_q;
    remaining_d = remaining_q;
    command_d   = command_q;
    sum_d       = sum_q;
    ev          = frp_pkg::EV_NONE;
    pvalid      = 1'b0;
    pindex      = '0;
    pbyte       = '0;
    case (phase_q)
      PH_IDLE: begin
        if (byte_i == cfg_i.head_code) phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_d = {byte_i, {frp_pkg::ByteW{1'b0}}};
        phase_d  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_d    = {length_q[frp_pkg::LenW-1:frp_pkg::ByteW], byte_i};
        remaining_d = {length_q[frp_pkg::LenW-1:frp_pkg::ByteW], byte_i};
        phase_d     = PH_CMD;
      end
      PH_CMD: begin
        command_d = byte_i;
        sum_d     = byte_i;
        // empty payload skips straight to the checksum
        phase_d   = (remaining_q == '0) ? PH_SUM : PH_DATA;
      end
      PH_DATA: begin
        pvalid      = 1'b1;
        pindex      = length_q - remaining_q;
        pbyte       = byte_i;
        sum_d       = sum_q + byte_i;
        remaining_d = remaining_q - 1'b1;
        if (remaining_q == frp_pkg::LenW'(1)) phase_d = PH_SUM;
      end
      PH_SUM: begin
        if (byte_i == sum_q) begin
          phase_d = PH_TAIL;
        end else begin
          ev      = frp_pkg::EV_SUM_BAD;
          phase_d = PH_IDLE;
        end
      end
      PH_TAIL: begin
        ev      = (byte_i == cfg_i.tail_code) ? frp_pkg::EV_OK : frp_pkg::EV_TAIL_BAD;
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // parser state, advanced once per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      length_q    <= '0;
      remaining_q <= '0;
      command_q   <= '0;
      sum_q       <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      length_q    <= length_d;
      remaining_q <= remaining_d;
      command_q   <= command_d;
      sum_q       <= sum_d;
    end
  end

  // result reflects the state after this byte
  always_comb begin
    res_o.event_res     = ev;
    res_o.frame_command = command_d;
    res_o.frame_length  = length_d;
    res_o.payload_valid = pvalid;
    res_o.payload_index = pindex;
    res_o.payload_byte  = pbyte;
  end

endmodule

// File: design/frp_result_reg.sv
// frp_result_reg: output register of the result channel with stall handling
// depends on frp_pkg
module frp_result_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  frp_pkg::res_t res_i,
  input  logic          stall_i,
  output logic          ready_o,
  output logic          valid_o,
  output frp_pkg::res_t res_o
);

  logic          valid_q, valid_d;
  frp_pkg::res_t res_q;

  // free when empty or when the held result is taken this cycle
  assign ready_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i)       valid_d = 1'b1;
    else if (ready_o) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: design/frame_receive_parser.sv
// frame_receive_parser: top level of the length-prefixed frame receiver
// depends on frp_pkg, frp_cfg_regs, frp_parser, frp_result_reg
//
// Usage
// - input channel: one received byte per transfer on rx_byte_i, in_valid_i / in_stall_o
// - result channel: one result per input byte on out_valid_o / out_stall_i: frame event,
//   current command and length, and the payload byte with its index when it is one
// - config port: cfg_we_i writes cfg_wdata_i to head code (index 0) or tail code
//   (index 1); write only while no byte is in flight
// - path: a taken byte is held in the input register, then passes through the parser
//   logic into the output register
// - throughput: one byte per cycle while out_stall_i is low, set by the single parser
//   step between the input and output registers
// - reset: parser idle waiting for a head byte, length/command/checksum zero, head
//   code 0xF5, tail code 0x5F, both pipeline registers empty
// - stall: while out_stall_i holds a result, the output register keeps it; once the
//   input register is also full, in_stall_o rises and no byte is lost
module frame_receive_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_addr_i,
  input  logic [frp_pkg::ByteW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [frp_pkg::ByteW-1:0] rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [frp_pkg::EvW-1:0]   event_res_o,
  output logic [frp_pkg::ByteW-1:0] frame_command_o,
  output logic [frp_pkg::LenW-1:0]  frame_length_o,
  output logic                      payload_valid_o,
  output logic [frp_pkg::LenW-1:0]  payload_index_o,
  output logic [frp_pkg::ByteW-1:0] payload_byte_o
);

  frp_pkg::cfg_t             cfg;
  frp_pkg::res_t             step_res;
  frp_pkg::res_t             out_res;
  logic                      in_valid_q, in_valid_d;
  logic [frp_pkg::ByteW-1:0] in_byte_q;
  logic                      out_ready;
  logic                      advance;
  logic                      in_take;

  frp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take)      in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_byte_q <= rx_byte_i;
  end

  frp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  frp_result_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .res_i   (step_res),
    .stall_i (out_stall_i),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .res_o   (out_res)
  );

  // result fields
  assign event_res_o     = out_res.event_res;
  assign frame_command_o = out_res.frame_command;
  assign frame_length_o  = out_res.frame_length;
  assign payload_valid_o = out_res.payload_valid;
  assign payload_index_o = out_res.payload_index;
  assign payload_byte_o  = out_res.payload_byte;

`ifndef ASSERT_OFF
  // payload bytes never carry a frame event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_valid_o) |-> (event_res_o == frp_pkg::EV_NONE))
    else $error("payload byte reported with a frame event");

  // non-payload results have zero index and byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !payload_valid_o) |-> (payload_index_o == '0 && payload_byte_o == '0))
    else $error("non-payload result carries payload data");

  // input stalls only when both registers are full and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without back-pressure");

  // a held byte moves on once the result register frees up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !(out_valid_o && out_stall_i)) |=> out_valid_o)
    else $error("held byte failed to reach the result register");
`endif

endmodule
